// ===== design/box_average_downscaler_defines.svh =====
// Assertion macros shared by the box average downscaler RTL.
`ifndef BOX_AVERAGE_DOWNSCALER_DEFINES_SVH
`define BOX_AVERAGE_DOWNSCALER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define BOX_AVG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("box_avg: same-cycle check failed");

// Next-cycle implication.
`define BOX_AVG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("box_avg: next-cycle check failed");

`endif

// ===== design/box_avg_pkg.sv =====
// Shared types, widths and constants of the box average downscaler.
package box_avg_pkg;

    localparam int PIX_W   = 8;
    localparam int NCH     = 3;
    localparam int SUM_W   = 21;
    localparam int QUOT_W  = 8;
    localparam int COORD_W = 12;
    localparam int IMG_MAX = 4096;
    localparam int IMG_W   = 13;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int DEF_MAX_CELLS_PER_ROW = 4096;
    localparam int DEF_MAX_CELL_WIDTH    = 64;
    localparam int DEF_MAX_CELL_HEIGHT   = 128;

    localparam logic [12:0] RST_IMAGE_WIDTH   = 13'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT  = 13'd480;
    localparam logic [6:0]  RST_CELL_WIDTH    = 7'd1;
    localparam logic [7:0]  RST_CELL_HEIGHT   = 8'd2;
    localparam logic [12:0] RST_CELLS_PER_ROW = 13'd640;
    localparam logic [12:0] RST_CELL_ROWS     = 13'd240;

    typedef logic [NCH-1:0][SUM_W-1:0]  t_sums;
    typedef logic [NCH-1:0][QUOT_W-1:0] t_quots;
    typedef logic [NCH-1:0][PIX_W-1:0]  t_pixel;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_CELL_WIDTH    = 3'd2,
        CFG_CELL_HEIGHT   = 3'd3,
        CFG_CELLS_PER_ROW = 3'd4,
        CFG_CELL_ROWS     = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_DIV,
        S_PUSH
    } t_state;

endpackage

// ===== design/box_avg_store.sv =====
// Column sum line store: registered read, one write port, clear sweep after reset.
module box_avg_store #(
    parameter int DEPTH = box_avg_pkg::DEF_MAX_CELLS_PER_ROW,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output box_avg_pkg::t_sums   o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  box_avg_pkg::t_sums   i_wr_data,
    output logic                 o_clearing
);
    import box_avg_pkg::*;

    t_sums         r_mem [DEPTH];
    t_sums         r_rd_data;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    logic          w_en;
    logic [AW-1:0] w_addr;
    t_sums         w_data;

    // Sweep zeros through every entry after reset, then hand the port over.
    always_comb begin
        if (r_clearing) begin
            w_en   = 1'b1;
            w_addr = r_clr_addr;
            w_data = '0;
        end else begin
            w_en   = i_wr_en;
            w_addr = i_wr_addr;
            w_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

// ===== design/box_avg_div.sv =====
// Three-channel restoring divider, one quotient bit per cycle, saturating at 255.
module box_avg_div #(
    parameter int DIV_W = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  box_avg_pkg::t_sums    i_sum,
    input  logic [DIV_W-1:0]      i_div,
    output logic                  o_busy,
    output box_avg_pkg::t_quots   o_quot
);
    import box_avg_pkg::*;

    localparam int RW  = (SUM_W > DIV_W + QUOT_W) ? SUM_W : DIV_W + QUOT_W;
    localparam int CNW = $clog2(QUOT_W + 1);

    logic [NCH-1:0][RW-1:0] r_rem;
    logic [RW-1:0]          r_dsh;
    logic [NCH-1:0]         r_sat;
    t_quots                 r_quot;
    logic [CNW-1:0]         r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNW'(QUOT_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNW'(1);
        end
    end

    // Load: flag sums of at least 256 times the divisor; step: try one shifted divisor.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dsh <= RW'(i_div) << (QUOT_W - 1);
            for (int c = 0; c < NCH; c++) begin
                r_rem[c]  <= RW'(i_sum[c]);
                r_sat[c]  <= RW'(i_sum[c]) >= (RW'(i_div) << QUOT_W);
                r_quot[c] <= '0;
            end
        end else if (r_cnt != '0) begin
            r_dsh <= r_dsh >> 1;
            for (int c = 0; c < NCH; c++) begin
                if (r_rem[c] >= r_dsh) begin
                    r_rem[c]  <= r_rem[c] - r_dsh;
                    r_quot[c] <= {r_quot[c][QUOT_W-2:0], 1'b1};
                end else begin
                    r_quot[c] <= {r_quot[c][QUOT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            o_quot[c] = r_sat[c] ? '1 : r_quot[c];
        end
    end

    assign o_busy = (r_cnt != '0);

endmodule

// ===== design/box_average_downscaler.sv =====
// Box average downscaler: averages RGB pixels over rectangular cells of a raster image.
// Pixels arrive in top-down raster order on the slave stream. Each counted
// cell column owns one entry of a line store that holds its red, green and
// blue sums; the first pixel of a cell overwrites the entry, the others add
// to it (sums wrap at 21 bits). When the last pixel of a cell arrives, the
// truncated mean of each channel (capped at 255) leaves on the master stream
// with the cell column and row, and tlast marks the last cell of a cell row.
// Pixels outside the first cells_per_row by cell_rows cells only move the
// counters. Steps: an ignored pixel is only accepted; a counted pixel that
// does not end its cell is accepted, then read-modify-written in the line
// store; one that ends a cell is accepted, read-modify-written, run through
// the 8-step divider that forms the three means in parallel (its steps,
// then the check that sees it done), and loaded into the output register. That
// load waits while the output register still holds an untaken result.
// A finished result waits in the output register, so the next pixel is taken
// while it is still pending. After reset the line store is swept to zero,
// one entry a cycle, during which no pixel is accepted; configuration writes
// are taken at any time and should be made between pixels only.
`include "box_average_downscaler_defines.svh"

module box_average_downscaler #(
    parameter int MAX_CELLS_PER_ROW = box_avg_pkg::DEF_MAX_CELLS_PER_ROW,
    parameter int MAX_CELL_WIDTH    = box_avg_pkg::DEF_MAX_CELL_WIDTH,
    parameter int MAX_CELL_HEIGHT   = box_avg_pkg::DEF_MAX_CELL_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [box_avg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [box_avg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    input  logic [23:0]                         s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] red_mean, [15:8] green_mean, [23:16] blue_mean,
    // [35:24] cell_column, [47:36] cell_row
    output logic [47:0]                         m_axis_tdata,
    // line_end
    output logic                                m_axis_tlast
);
    import box_avg_pkg::*;

    localparam int AW   = (MAX_CELLS_PER_ROW > 1) ? $clog2(MAX_CELLS_PER_ROW) : 1;
    localparam int CXW  = $clog2(MAX_CELLS_PER_ROW + 1);
    localparam int CWW  = $clog2(MAX_CELL_WIDTH + 1);
    localparam int CHW  = $clog2(MAX_CELL_HEIGHT + 1);
    localparam int XW   = (MAX_CELL_WIDTH > 1) ? $clog2(MAX_CELL_WIDTH) : 1;
    localparam int YW   = (MAX_CELL_HEIGHT > 1) ? $clog2(MAX_CELL_HEIGHT) : 1;
    localparam int DIVW = CWW + CHW;

    // Configuration registers.
    logic [12:0] r_image_width, r_image_height, r_cells_per_row, r_cell_rows;
    logic [6:0]  r_cell_width;
    logic [7:0]  r_cell_height;

    // Raster and cell position.
    logic [COORD_W-1:0] r_px, r_py;
    logic [XW-1:0]      r_x;
    logic [YW-1:0]      r_y;
    logic [CXW-1:0]     r_cx;
    logic [IMG_W-1:0]   r_cy;

    // Request held while it is worked on.
    t_pixel             r_pix;
    logic               r_first, r_last, r_line_end;
    logic [AW-1:0]      r_addr;
    logic [DIVW-1:0]    r_div;
    logic [COORD_W-1:0] r_ocx, r_ocy;

    // Output register.
    logic               r_out_valid, r_out_last;
    logic [47:0]        r_out_data;

    t_state r_state, n_state;

    // Clamped settings.
    logic [IMG_W-1:0] iw_eff, ih_eff, cr_eff;
    logic [CWW-1:0]   cw_eff;
    logic [CHW-1:0]   ch_eff;
    logic [CXW-1:0]   cpr_eff;

    logic  accept, last_x, last_y, active;
    logic  st_clearing, st_rd_en, st_wr_en, div_start, div_busy, out_load;
    t_sums st_rd_data, new_sums;
    t_quots quot;

    always_comb begin
        iw_eff  = (r_image_width == '0) ? IMG_W'(1)
                : (32'(r_image_width) > IMG_MAX) ? IMG_W'(IMG_MAX) : r_image_width;
        ih_eff  = (r_image_height == '0) ? IMG_W'(1)
                : (32'(r_image_height) > IMG_MAX) ? IMG_W'(IMG_MAX) : r_image_height;
        cr_eff  = (r_cell_rows == '0) ? IMG_W'(1)
                : (32'(r_cell_rows) > IMG_MAX) ? IMG_W'(IMG_MAX) : r_cell_rows;
        cw_eff  = (r_cell_width == '0) ? CWW'(1)
                : (32'(r_cell_width) > MAX_CELL_WIDTH) ? CWW'(MAX_CELL_WIDTH)
                : CWW'(r_cell_width);
        ch_eff  = (r_cell_height == '0) ? CHW'(1)
                : (32'(r_cell_height) > MAX_CELL_HEIGHT) ? CHW'(MAX_CELL_HEIGHT)
                : CHW'(r_cell_height);
        cpr_eff = (r_cells_per_row == '0) ? CXW'(1)
                : (32'(r_cells_per_row) > MAX_CELLS_PER_ROW) ? CXW'(MAX_CELLS_PER_ROW)
                : CXW'(r_cells_per_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= RST_IMAGE_WIDTH;
            r_image_height  <= RST_IMAGE_HEIGHT;
            r_cell_width    <= RST_CELL_WIDTH;
            r_cell_height   <= RST_CELL_HEIGHT;
            r_cells_per_row <= RST_CELLS_PER_ROW;
            r_cell_rows     <= RST_CELL_ROWS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data;
                CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data;
                CFG_CELL_WIDTH:    r_cell_width    <= i_cfg_data[6:0];
                CFG_CELL_HEIGHT:   r_cell_height   <= i_cfg_data[7:0];
                CFG_CELLS_PER_ROW: r_cells_per_row <= i_cfg_data;
                CFG_CELL_ROWS:     r_cell_rows     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign accept = s_axis_tvalid && s_axis_tready;
    assign last_x = 32'(r_x) >= 32'(cw_eff) - 32'd1;
    assign last_y = 32'(r_y) >= 32'(ch_eff) - 32'd1;
    assign active = (32'(r_cx) < 32'(cpr_eff)) && (32'(r_cy) < 32'(cr_eff));

    // Advance the raster counters on every accepted pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
            r_x  <= '0;
            r_y  <= '0;
            r_cx <= '0;
            r_cy <= '0;
        end else if (accept) begin
            if (32'(r_px) >= 32'(iw_eff) - 32'd1) begin
                r_px <= '0;
                r_x  <= '0;
                r_cx <= '0;
                if (32'(r_py) >= 32'(ih_eff) - 32'd1) begin
                    r_py <= '0;
                    r_y  <= '0;
                    r_cy <= '0;
                end else begin
                    r_py <= r_py + COORD_W'(1);
                    if (last_y) begin
                        r_y <= '0;
                        if (32'(r_cy) < 32'(cr_eff)) begin
                            r_cy <= r_cy + IMG_W'(1);
                        end
                    end else begin
                        r_y <= r_y + YW'(1);
                    end
                end
            end else begin
                r_px <= r_px + COORD_W'(1);
                if (last_x) begin
                    r_x <= '0;
                    if (32'(r_cx) < 32'(cpr_eff)) begin
                        r_cx <= r_cx + CXW'(1);
                    end
                end else begin
                    r_x <= r_x + XW'(1);
                end
            end
        end
    end

    // Capture the request; the line store read is issued at the same edge.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix      <= s_axis_tdata;
            r_first    <= (r_x == '0) && (r_y == '0);
            r_last     <= last_x && last_y;
            r_line_end <= 32'(r_cx) == 32'(cpr_eff) - 32'd1;
            r_addr     <= r_cx[AW-1:0];
            r_div      <= DIVW'(cw_eff) * DIVW'(ch_eff);
            r_ocx      <= COORD_W'(r_cx);
            r_ocy      <= COORD_W'(r_cy);
        end
    end

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            new_sums[c] = r_first ? SUM_W'(r_pix[c]) : st_rd_data[c] + SUM_W'(r_pix[c]);
        end
    end

    box_avg_store #(
        .DEPTH (MAX_CELLS_PER_ROW),
        .AW    (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (st_rd_en),
        .i_rd_addr  (r_cx[AW-1:0]),
        .o_rd_data  (st_rd_data),
        .i_wr_en    (st_wr_en),
        .i_wr_addr  (r_addr),
        .i_wr_data  (new_sums),
        .o_clearing (st_clearing)
    );

    box_avg_div #(
        .DIV_W (DIVW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (new_sums),
        .i_div   (r_div),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (!st_clearing) n_state = S_IDLE;
            S_IDLE:  if (s_axis_tvalid && active) n_state = S_ADD;
            S_ADD:   n_state = r_last ? S_DIV : S_IDLE;
            S_DIV:   if (!div_busy) n_state = S_PUSH;
            S_PUSH:  if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        st_rd_en      = 1'b0;
        st_wr_en      = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            S_CLEAR: ;
            S_IDLE: begin
                s_axis_tready = 1'b1;
                st_rd_en      = s_axis_tvalid && active;
            end
            S_ADD: begin
                st_wr_en  = 1'b1;
                div_start = r_last;
            end
            S_DIV: ;
            S_PUSH:  out_load = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    // Hold the result until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {r_ocy, r_ocx, quot[2], quot[1], quot[0]};
            r_out_last <= r_line_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    `BOX_AVG_ASSERT_NOW(a_no_pixel_while_clearing, st_clearing, !s_axis_tready)
    `BOX_AVG_ASSERT_NEXT(a_div_follows_cell_end, (r_state == S_ADD) && r_last, div_busy)
    `BOX_AVG_ASSERT_NEXT(a_push_fills_output, out_load, r_out_valid && (r_state == S_IDLE))
    `BOX_AVG_ASSERT_NOW(a_write_only_in_add, st_wr_en, r_state == S_ADD && !st_clearing)

endmodule

// ===== dv/box_avg_checker.sv =====
// Checker for the box average downscaler: predicts cell means and compares the output stream.
module box_avg_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [box_avg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [box_avg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    input  logic [23:0]                        i_s_tdata,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [47:0]                        i_m_tdata,
    input  logic                               i_m_tlast,
    output int                                 o_pending,
    output int                                 o_errors
);
    timeunit 1ns;
    timeprecision 1ps;
    import box_avg_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        t_quots             means;
        logic               last;
    } t_cell_mean;

    t_cell_mean cell_means_due[$];

    logic [IMG_W-1:0] img_w, img_h, cells_across, cell_rows_n;
    logic [6:0]       box_w;
    logic [7:0]       box_h;

    logic [SUM_W-1:0] col_sum [NCH][DEF_MAX_CELLS_PER_ROW];
    int unsigned px, py, xc, yc, cx, cy;
    int errs;

    function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic accumulate(t_pixel p);
        int unsigned iw, ih, cw, ch, cpr, cr, q;
        bit last_x, last_y;
        t_cell_mean m;
        iw = clip(32'(img_w), 1, IMG_MAX);
        ih = clip(32'(img_h), 1, IMG_MAX);
        cw = clip(32'(box_w), 1, DEF_MAX_CELL_WIDTH);
        ch = clip(32'(box_h), 1, DEF_MAX_CELL_HEIGHT);
        cpr = clip(32'(cells_across), 1, DEF_MAX_CELLS_PER_ROW);
        cr = clip(32'(cell_rows_n), 1, IMG_MAX);
        last_x = xc >= cw - 1;
        last_y = yc >= ch - 1;
        if (cx < cpr && cy < cr) begin
            for (int c = 0; c < NCH; c++) begin
                // first pixel of a cell overwrites the entry
                if (xc == 0 && yc == 0) col_sum[c][cx] = SUM_W'(p[c]);
                else col_sum[c][cx] = col_sum[c][cx] + SUM_W'(p[c]);
            end
            if (last_x && last_y) begin
                for (int c = 0; c < NCH; c++) begin
                    q = col_sum[c][cx] / (cw * ch);
                    m.means[c] = (q > 255) ? 8'hFF : q[7:0];
                end
                m.col = cx[COORD_W-1:0];
                m.row = cy[COORD_W-1:0];
                m.last = (cx == cpr - 1);
                cell_means_due.push_back(m);
            end
        end
        if (px >= iw - 1) begin
            px = 0; xc = 0; cx = 0;
            if (py >= ih - 1) begin
                py = 0; yc = 0; cy = 0;
            end else begin
                py++;
                if (last_y) begin
                    yc = 0;
                    if (cy < cr) cy++;
                end else yc++;
            end
        end else begin
            px++;
            if (last_x) begin
                xc = 0;
                if (cx < cpr) cx++;
            end else xc++;
        end
    endtask

    task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            errs++;
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_cell_mean want;
        if (!i_rst_n) begin
            img_w = RST_IMAGE_WIDTH; img_h = RST_IMAGE_HEIGHT;
            box_w = RST_CELL_WIDTH; box_h = RST_CELL_HEIGHT;
            cells_across = RST_CELLS_PER_ROW; cell_rows_n = RST_CELL_ROWS;
            for (int c = 0; c < NCH; c++)
                for (int i = 0; i < DEF_MAX_CELLS_PER_ROW; i++) col_sum[c][i] = '0;
            px = 0; py = 0; xc = 0; yc = 0; cx = 0; cy = 0;
            cell_means_due.delete();
            errs = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_IMAGE_WIDTH:   img_w = i_cfg_data;
                    CFG_IMAGE_HEIGHT:  img_h = i_cfg_data;
                    CFG_CELL_WIDTH:    box_w = i_cfg_data[6:0];
                    CFG_CELL_HEIGHT:   box_h = i_cfg_data[7:0];
                    CFG_CELLS_PER_ROW: cells_across = i_cfg_data;
                    CFG_CELL_ROWS:     cell_rows_n = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) accumulate(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (cell_means_due.size() == 0) begin
                    errs++;
                    $display("%0t mismatch: expected nothing, actual %h last %b",
                             $time, i_m_tdata, i_m_tlast);
                end else begin
                    want = cell_means_due.pop_front();
                    check_field("red_mean", 32'(want.means[0]), 32'(i_m_tdata[7:0]));
                    check_field("green_mean", 32'(want.means[1]), 32'(i_m_tdata[15:8]));
                    check_field("blue_mean", 32'(want.means[2]), 32'(i_m_tdata[23:16]));
                    check_field("cell_column", 32'(want.col), 32'(i_m_tdata[35:24]));
                    check_field("cell_row", 32'(want.row), 32'(i_m_tdata[47:36]));
                    check_field("line_end", 32'(want.last), 32'(i_m_tlast));
                end
            end
        end
        o_pending <= cell_means_due.size();
        o_errors <= errs;
    end
endmodule

// ===== dv/tb.sv =====
// Top of the box average downscaler testbench: stimulus, flow control and verdict.
module tb;
    import box_avg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Stall-free stretch long enough for the post-reset line store sweep.
    localparam int WATCHDOG_LIMIT = 50000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata;   // red_in, green_in, blue_in from bit 0 up
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [47:0]           m_axis_tdata;   // red, green, blue means, cell_column, cell_row
    logic                  m_axis_tlast;   // line_end

    int pending, errors;
    int gap_pct, stall_pct;
    int hold_token, hold_seen, hold_left;
    int pixels_sent, quiet_cycles;

    always #2 i_clk = ~i_clk;

    box_average_downscaler i_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
    );

    box_avg_checker i_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready), .i_s_tdata(s_axis_tdata),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .i_m_tlast(m_axis_tlast), .o_pending(pending), .o_errors(errors)
    );

    // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: end the run if no request moves on either stream for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int unsigned eff(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel p;
        p = t_pixel'($urandom);
        // bias some channels to the extremes
        for (int c = 0; c < NCH; c++)
            if ($urandom_range(0, 7) == 0) p[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return p;
    endfunction

    task automatic set_idling(int mode);
        case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 82; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 82; end
            default: begin gap_pct = 19; stall_pct = 19; end
        endcase
    endtask

    // Offer one pixel, with random gaps first; hold tvalid high after the request.
    task automatic send_pixel(t_pixel p);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        do @(posedge i_clk); while (!s_axis_tready);
        pixels_sent++;
    endtask

    // Drop tvalid and wait until every expected cell mean has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
    endtask

    // Reconfigure only once the block is idle, allowing for its divide latency.
    task automatic configure(int unsigned iw, int unsigned ih, int unsigned cw,
                             int unsigned ch, int unsigned cpr, int unsigned cr);
        drain();
        repeat (16) @(posedge i_clk);
        put_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(iw));
        put_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(ih));
        put_reg(CFG_CELL_WIDTH, CFG_DATA_W'(cw));
        put_reg(CFG_CELL_HEIGHT, CFG_DATA_W'(ch));
        put_reg(CFG_CELLS_PER_ROW, CFG_DATA_W'(cpr));
        put_reg(CFG_CELL_ROWS, CFG_DATA_W'(cr));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_frames(int n, int hold_at, int pause_at, bit all_max);
        for (int k = 0; k < n; k++) begin
            if (k == hold_at) hold_token++;
            if (k == pause_at) drain();
            send_pixel(all_max ? t_pixel'('1) : rand_pixel());
        end
    endtask

    initial begin
        int unsigned iw, ih, cw, ch, cpr, cr, n;
        int phase;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_IMAGE_WIDTH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        gap_pct = 0; stall_pct = 0;
        hold_token = 0; hold_seen = 0; hold_left = 0;
        pixels_sent = 0; quiet_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(0);

        // One cell per pixel: extreme colors straight through.
        configure(4, 2, 1, 1, 4, 2);
        send_pixel('0);
        send_pixel('1);
        send_pixel(24'h0000FF);
        send_pixel(24'h00FF00);
        send_pixel(24'hFF0000);
        send_pixel(24'h55AA55);
        send_pixel(24'hAA55AA);
        send_pixel(24'h7F8001);
        // Zero registers act as one.
        configure(0, 0, 0, 0, 0, 0);
        repeat (3) send_pixel(rand_pixel());
        // Pixels outside the counted cells are ignored.
        configure(5, 4, 2, 2, 2, 1);
        send_frames(20, -1, -1, 0);
        // Widest and tallest cells, clamped from oversize values, all 255.
        configure(64, 1, 127, 1, 1, 1);
        send_frames(64, -1, -1, 1);
        configure(1, 128, 1, 255, 1, 1);
        send_frames(128, -1, -1, 1);
        // Oversize width and counts clamp; every pixel ends a cell, so a long
        // receiver hold-off fills the block and stalls its input, then a pause
        // lets every result out.
        configure(8191, 1, 1, 1, 8191, 8191);
        send_frames(64, 8, 40, 0);

        phase = 0;
        while (pixels_sent < 650) begin
            set_idling(phase < 4 ? phase : $urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0) begin
                // Noise: a random register value and a broken frame.
                drain();
                repeat (16) @(posedge i_clk);
                case ($urandom_range(0, 5))
                    0: put_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom));
                    1: put_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'($urandom));
                    2: put_reg(CFG_CELL_WIDTH, CFG_DATA_W'($urandom));
                    3: put_reg(CFG_CELL_HEIGHT, CFG_DATA_W'($urandom));
                    4: put_reg(CFG_CELLS_PER_ROW, CFG_DATA_W'($urandom));
                    default: put_reg(CFG_CELL_ROWS, CFG_DATA_W'($urandom));
                endcase
                i_cfg_we <= 1'b0;
                send_frames($urandom_range(1, 40), -1, -1, 0);
            end else begin
                iw = $urandom_range(1, 12);
                ih = $urandom_range(1, 8);
                cw = $urandom_range(1, 4);
                ch = $urandom_range(1, 4);
                cpr = $urandom_range(1, 4);
                cr = $urandom_range(1, 3);
                configure(iw, ih, cw, ch, cpr, cr);
                n = eff(iw, IMG_MAX) * eff(ih, IMG_MAX) * $urandom_range(1, 2);
                // Occasionally cut the frame short.
                if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
                send_frames(n, (phase == 1) ? n / 4 : -1, (phase == 2) ? n / 2 : -1, 0);
            end
            phase++;
        end

        drain();
        repeat (30) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
